// File: rtl/midi_tep_pkg.sv
// Types and constants for the MIDI track event parser.
// No dependencies; used by every module of the block.
package midi_tep_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  note_number;
    logic [6:0]  note_velocity;
    logic [3:0]  channel;
    logic [27:0] delta_ticks;
  } out_item_t;

  typedef enum logic [7:0] {
    PH_DELTA     = 8'b0000_0001,
    PH_STATUS    = 8'b0000_0010,
    PH_NOTE      = 8'b0000_0100,
    PH_VELOCITY  = 8'b0000_1000,
    PH_SKIP      = 8'b0001_0000,
    PH_META_TYPE = 8'b0010_0000,
    PH_META_LEN  = 8'b0100_0000,
    PH_SYSEX     = 8'b1000_0000
  } phase_e;

  localparam int unsigned QtyWidth = 28;

  localparam logic [7:0] StatusSysFirst = 8'hF0;
  localparam logic [7:0] StatusMeta     = 8'hFF;
  localparam logic [7:0] StatusEox      = 8'hF7;

  localparam logic [3:0] KindNoteOn     = 4'h9;
  localparam logic [3:0] KindProgram    = 4'hC;
  localparam logic [3:0] KindPressure   = 4'hD;

endpackage

// File: rtl/midi_tep_parser.sv
// Parser state and next-state logic: one byte per step.
// Depends on midi_tep_pkg.
module midi_tep_parser import midi_tep_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output logic      res_valid_o,
  output out_item_t res_item_o
);

  phase_e                phase_q, phase_d, phase_cur;
  logic [7:0]            status_q, status_d, status_cur, status_new;
  logic [QtyWidth-1:0]   delta_q, delta_d, delta_cur;
  logic [6:0]            first_q, first_d, first_cur;
  logic [QtyWidth-1:0]   skip_q, skip_d, skip_cur, meta_len;
  logic [7:0]            b;
  logic                  running;

  assign b = item_i.data_byte;

  // track start clears everything before the byte is taken
  always_comb begin
    if (item_i.track_start) begin
      phase_cur  = PH_DELTA;
      status_cur = '0;
      delta_cur  = '0;
      first_cur  = '0;
      skip_cur   = '0;
    end else begin
      phase_cur  = phase_q;
      status_cur = status_q;
      delta_cur  = delta_q;
      first_cur  = first_q;
      skip_cur   = skip_q;
    end
  end

  assign running    = ~b[7];
  assign status_new = running ? status_cur : b;
  assign meta_len   = {skip_cur[QtyWidth-8:0], b[6:0]};

  always_comb begin
    phase_d     = phase_cur;
    status_d    = status_cur;
    delta_d     = delta_cur;
    first_d     = first_cur;
    skip_d      = skip_cur;
    res_valid_o = 1'b0;
    res_item_o  = '{note_number:   first_cur,
                    note_velocity: b[6:0],
                    channel:       status_cur[3:0],
                    delta_ticks:   delta_cur};
    unique case (phase_cur)
      PH_DELTA: begin
        delta_d = {delta_cur[QtyWidth-8:0], b[6:0]};
        if (!b[7]) begin
          phase_d = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (running && status_cur == '0) begin
          // data byte with no running status is dropped
          phase_d = PH_DELTA;
          delta_d = '0;
          skip_d  = '0;
        end else if (!running && b >= StatusSysFirst) begin
          status_d = '0;
          phase_d  = (b == StatusMeta) ? PH_META_TYPE : PH_SYSEX;
        end else begin
          status_d = status_new;
          if (status_new[7:4] == KindNoteOn) begin
            if (running) begin
              first_d = b[6:0];
              phase_d = PH_VELOCITY;
            end else begin
              phase_d = PH_NOTE;
            end
          end else if (status_new[7:4] == KindProgram ||
                       status_new[7:4] == KindPressure) begin
            if (running) begin
              phase_d = PH_DELTA;
              delta_d = '0;
              skip_d  = '0;
            end else begin
              skip_d  = QtyWidth'(1);
              phase_d = PH_SKIP;
            end
          end else begin
            skip_d  = running ? QtyWidth'(1) : QtyWidth'(2);
            phase_d = PH_SKIP;
          end
        end
      end
      PH_NOTE: begin
        first_d = b[6:0];
        phase_d = PH_VELOCITY;
      end
      PH_VELOCITY: begin
        res_valid_o = (b[6:0] != '0);
        phase_d     = PH_DELTA;
        delta_d     = '0;
        skip_d      = '0;
      end
      PH_SKIP: begin
        skip_d = skip_cur - QtyWidth'(1);
        if (skip_d == '0) begin
          phase_d = PH_DELTA;
          delta_d = '0;
        end
      end
      PH_META_TYPE: begin
        skip_d  = '0;
        phase_d = PH_META_LEN;
      end
      PH_META_LEN: begin
        skip_d = meta_len;
        if (!b[7]) begin
          if (meta_len == '0) begin
            phase_d = PH_DELTA;
            delta_d = '0;
          end else begin
            phase_d = PH_SKIP;
          end
        end
      end
      PH_SYSEX: begin
        if (b == StatusEox) begin
          phase_d = PH_DELTA;
          delta_d = '0;
          skip_d  = '0;
        end
      end
      default: begin
        phase_d = PH_DELTA;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DELTA;
      status_q <= '0;
      delta_q  <= '0;
      first_q  <= '0;
      skip_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      status_q <= status_d;
      delta_q  <= delta_d;
      first_q  <= first_d;
      skip_q   <= skip_d;
    end
  end

endmodule

// File: rtl/midi_track_event_parser_core.sv
// MIDI track event parser: takes one track byte per cycle, back to back. A byte is captured in
// the input register, the parser state machine decodes it, and a note-on result lands in the result
// register, so a result is valid once its last byte has passed the input and result registers.
// Throughput is one byte per clock while the result side is free; the input
// stalls only while the result register is full and the output side stalls.
module midi_track_event_parser_core import midi_tep_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      out_free;
  logic      advance;
  logic      res_valid;
  out_item_t res_item;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign advance    = in_valid_q & out_free;
  assign in_stall_o = in_valid_q & ~out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  midi_tep_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_item_q),
    .res_valid_o (res_valid),
    .res_item_o  (res_item)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance & res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: rtl/midi_tep_checker.sv
// Port-level checks for the MIDI track event parser, bound to the top level.
// Depends on midi_tep_pkg.
module midi_tep_checker import midi_tep_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  // input only backs up when the result side is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free result register");

  // note-on results never carry zero velocity
  a_velocity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.note_velocity != '0)
    else $error("result with zero velocity");

  // a fresh result comes from an item accepted through the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching accepted item");

endmodule

bind midi_track_event_parser_core midi_tep_checker u_chk (.*);

// File: verif/tb.sv
// Self-checking testbench for midi_track_event_parser_core: drives track bytes, predicts
// the note-on items from its own parser model and checks them in order on the output side.
// Depends on midi_tep_pkg and the core RTL only.
module tb;
  import midi_tep_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned PhaseBytes = 284;

  localparam logic [3:0] KindNoteOff   = 4'h8;
  localparam logic [3:0] KindPolyTouch = 4'hA;
  localparam logic [3:0] KindControl   = 4'hB;
  localparam logic [3:0] KindPitchBend = 4'hE;

  // opening track: plain note-on, wrapped max delta with running status and a flagged
  // velocity, zero velocity, empty meta, data byte with no running status, cut-off note
  localparam int unsigned OpeningLen = 24;
  localparam logic [OpeningLen*8-1:0] OpeningBytes = {
    8'h00, KindNoteOn, 4'h0, 8'h00, 8'h7F,
    8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h7F, 8'hFF,
    8'h00, KindNoteOn, 4'hF, 8'h40, 8'h80,
    8'h00, StatusMeta, 8'h2F, 8'h00,
    8'h00, 8'h45,
    8'h00, KindNoteOn, 4'hA, 8'h3C
  };

  typedef enum int unsigned {
    PACE_SLOW_SINK,
    PACE_SLOW_SOURCE,
    PACE_FULL_RATE
  } pace_e;

  typedef struct {
    in_item_t item;
    pace_e    pace;
    bit       drain_first;
  } feed_t;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  feed_t       feed_q[$];
  out_item_t   expected_notes[$];
  logic [7:0]  ev_bytes[$];
  pace_e       pace = PACE_SLOW_SINK;
  pace_e       fill_pace = PACE_SLOW_SINK;
  bit          fill_drain = 1'b0;
  bit          next_track = 1'b0;
  logic [7:0]  gen_status = '0;
  int unsigned taken_cnt = 0;
  int unsigned fault_cnt = 0;
  int unsigned cycle_cnt = 0;

  // parser model state
  phase_e      pred_phase = PH_DELTA;
  logic [7:0]  pred_status = '0;
  logic [27:0] pred_delta = '0;
  logic [6:0]  pred_note = '0;
  logic [27:0] pred_skip = '0;

  midi_track_event_parser_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void close_event();
    pred_phase = PH_DELTA;
    pred_delta = '0;
    pred_skip  = '0;
  endfunction

  function automatic void skip_bytes(input logic [27:0] count);
    if (count == '0) begin
      close_event();
    end else begin
      pred_skip  = count;
      pred_phase = PH_SKIP;
    end
  endfunction

  // advance the parser model by one byte, returns 1 when a note-on item is due
  function automatic bit decode_byte(input in_item_t it, output out_item_t note);
    logic [7:0] b;
    logic [3:0] kind;
    bit         running;
    b = it.data_byte;
    note = '0;
    decode_byte = 1'b0;
    if (it.track_start) begin
      pred_phase  = PH_DELTA;
      pred_status = '0;
      pred_delta  = '0;
      pred_note   = '0;
      pred_skip   = '0;
    end
    case (pred_phase)
      PH_STATUS: begin
        running = !b[7];
        if (running && pred_status == '0) begin
          close_event();
        end else if (!running && b >= StatusSysFirst) begin
          // meta and sysex drop the running status
          pred_status = '0;
          if (b == StatusMeta) begin
            pred_phase = PH_META_TYPE;
          end else begin
            pred_phase = PH_SYSEX;
          end
        end else begin
          if (!running) begin
            pred_status = b;
          end
          kind = pred_status[7:4];
          if (kind == KindNoteOn && running) begin
            pred_note  = b[6:0];
            pred_phase = PH_VELOCITY;
          end else if (kind == KindNoteOn) begin
            pred_phase = PH_NOTE;
          end else if (kind == KindProgram || kind == KindPressure) begin
            skip_bytes(running ? 28'd0 : 28'd1);
          end else begin
            skip_bytes(running ? 28'd1 : 28'd2);
          end
        end
      end
      PH_NOTE: begin
        pred_note  = b[6:0];
        pred_phase = PH_VELOCITY;
      end
      PH_VELOCITY: begin
        if (b[6:0] != '0) begin
          note.note_number   = pred_note;
          note.note_velocity = b[6:0];
          note.channel       = pred_status[3:0];
          note.delta_ticks   = pred_delta;
          decode_byte = 1'b1;
        end
        close_event();
      end
      PH_SKIP: begin
        pred_skip = pred_skip - 1'b1;
        if (pred_skip == '0) begin
          close_event();
        end
      end
      PH_META_TYPE: begin
        pred_skip  = '0;
        pred_phase = PH_META_LEN;
      end
      PH_META_LEN: begin
        pred_skip = {pred_skip[20:0], b[6:0]};
        if (!b[7]) begin
          skip_bytes(pred_skip);
        end
      end
      PH_SYSEX: begin
        if (b == StatusEox) begin
          close_event();
        end
      end
      default: begin
        pred_phase = PH_DELTA;
        pred_delta = {pred_delta[20:0], b[6:0]};
        if (!b[7]) begin
          pred_phase = PH_STATUS;
        end
      end
    endcase
  endfunction

  task automatic put(input logic [7:0] value, input bit start);
    feed_t f;
    f.item.data_byte   = value;
    f.item.track_start = start;
    f.pace             = fill_pace;
    f.drain_first      = fill_drain;
    fill_drain = 1'b0;
    feed_q.push_back(f);
  endtask

  // padded form has five bytes, the top group lands above bit 27 and wraps away
  task automatic add_vlq(input logic [27:0] value, input bit padded);
    logic [34:0] groups;
    int          n;
    groups = {padded ? 7'($urandom_range(0, 127)) : 7'd0, value};
    if (padded) n = 5;
    else if (value < 28'h80) n = 1;
    else if (value < 28'h4000) n = 2;
    else if (value < 28'h200000) n = 3;
    else n = 4;
    for (int i = n - 1; i >= 0; i--) begin
      ev_bytes.push_back({i != 0, groups[7*i +: 7]});
    end
  endtask

  function automatic logic [7:0] rand_data();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] pick_velocity();
    if ($urandom_range(0, 9) == 0) return {1'($urandom_range(0, 1)), 7'd0};
    return rand_data();
  endfunction

  // one event with random content; now and then a noisy or cut-off one
  task automatic put_event();
    logic [3:0]  chan;
    logic [3:0]  kind;
    logic [31:0] delta;
    int unsigned pick;
    int unsigned n;
    bit          new_track;
    ev_bytes.delete();
    new_track = next_track || $urandom_range(0, 24) == 0;
    next_track = 1'b0;
    if (new_track) gen_status = '0;
    chan = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0: delta = 0;
      1: delta = $urandom_range(1, 127);
      2: delta = $urandom_range(128, 16383);
      default: delta = $urandom;
    endcase
    add_vlq(delta[27:0], $urandom_range(0, 19) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      gen_status = {KindNoteOn, chan};
      ev_bytes.push_back(gen_status);
      ev_bytes.push_back(rand_data());
      ev_bytes.push_back(pick_velocity());
    end else if (pick < 55) begin
      // running status, first data byte must look like data
      ev_bytes.push_back(8'($urandom_range(0, 127)));
      if (gen_status[7:4] == KindNoteOn) begin
        ev_bytes.push_back(pick_velocity());
      end else if (gen_status[7:4] != KindProgram && gen_status[7:4] != KindPressure) begin
        ev_bytes.push_back(rand_data());
      end
    end else if (pick < 72) begin
      case ($urandom_range(0, 5))
        0: kind = KindNoteOff;
        1: kind = KindPolyTouch;
        2: kind = KindControl;
        3: kind = KindProgram;
        4: kind = KindPressure;
        default: kind = KindPitchBend;
      endcase
      gen_status = {kind, chan};
      ev_bytes.push_back(gen_status);
      ev_bytes.push_back(rand_data());
      if (kind != KindProgram && kind != KindPressure) ev_bytes.push_back(rand_data());
    end else if (pick < 82) begin
      gen_status = '0;
      ev_bytes.push_back(StatusMeta);
      ev_bytes.push_back(rand_data());
      n = $urandom_range(0, 6);
      add_vlq(28'(n), $urandom_range(0, 9) == 0);
      repeat (n) ev_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 92) begin
      gen_status = '0;
      ev_bytes.push_back(8'($urandom_range(StatusSysFirst, StatusMeta - 1'b1)));
      repeat ($urandom_range(0, 4)) ev_bytes.push_back(8'($urandom_range(0, StatusEox - 1'b1)));
      ev_bytes.push_back(StatusEox);
    end else begin
      // garbage where a status belongs
      repeat ($urandom_range(1, 2)) ev_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if (ev_bytes.size() > 1 && $urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, ev_bytes.size() - 1);
      while (ev_bytes.size() > n) void'(ev_bytes.pop_back());
      next_track = 1'b1;
    end
    foreach (ev_bytes[i]) put(ev_bytes[i], new_track && i == 0);
  endtask

  always @(posedge clk_i) begin : drive
    out_item_t note;
    bit        hit;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        hit = decode_byte(in_item, note);
        if (hit) expected_notes.push_back(note);
        taken_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (feed_q.size() != 0 && !(feed_q[0].drain_first && expected_notes.size() != 0) &&
            $urandom_range(0, 99) >= ((feed_q[0].pace == PACE_SLOW_SINK)   ? 15 :
                                      (feed_q[0].pace == PACE_SLOW_SOURCE) ? 88 : 0)) begin
          in_item  <= feed_q[0].item;
          in_valid <= 1'b1;
          pace     <= feed_q[0].pace;
          void'(feed_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watch
    out_item_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_notes.size() == 0) begin
          if (fault_cnt < 10) begin
            $display("unexpected note-on item: note %0d vel %0d ch %0d delta %0h",
                     out_item.note_number, out_item.note_velocity, out_item.channel,
                     out_item.delta_ticks);
          end
          fault_cnt++;
        end else begin
          want = expected_notes.pop_front();
          if (out_item.note_number !== want.note_number ||
              out_item.note_velocity !== want.note_velocity ||
              out_item.channel !== want.channel ||
              out_item.delta_ticks !== want.delta_ticks) begin
            if (fault_cnt < 10) begin
              $display("note-on mismatch: expected note %0d vel %0d ch %0d delta %0h, got note %0d vel %0d ch %0d delta %0h",
                       want.note_number, want.note_velocity, want.channel, want.delta_ticks,
                       out_item.note_number, out_item.note_velocity, out_item.channel,
                       out_item.delta_ticks);
            end
            fault_cnt++;
          end
        end
      end
      out_stall <= $urandom_range(0, 99) < ((pace == PACE_SLOW_SINK)   ? 88 :
                                             (pace == PACE_SLOW_SOURCE) ? 15 : 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : main
    int unsigned total;
    for (int i = 0; i < OpeningLen; i++) begin
      put(OpeningBytes[(OpeningLen - 1 - i)*8 +: 8], i == 0);
    end
    next_track = 1'b1;
    // each pacing phase after the first waits for the output side to empty first
    for (int p = 0; p < 3; p++) begin
      fill_pace  = pace_e'(p);
      fill_drain = (p != 0);
      while (feed_q.size() < OpeningLen + (p + 1) * PhaseBytes) put_event();
    end
    total = feed_q.size();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (taken_cnt != total || expected_notes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/midi_tep_pkg.sv
rtl/midi_tep_parser.sv
rtl/midi_track_event_parser_core.sv
rtl/midi_tep_checker.sv
verif/tb.sv
